FILE: hdl/vsc_pkg.sv
`timescale 1ns / 1ps

package vsc_pkg;

    // Fixed widths of the transaction fields.
    localparam int COORD_W   = 7;
    localparam int ID_W      = 8;
    localparam int CNT_OUT_W = 16;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_MAC = 2'd0,
        OP_DEC = 2'd1,
        OP_INC = 2'd2
    } t_alu_op;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_CLEAR = 9'b0_0000_0001,
        ST_IDLE  = 9'b0_0000_0010,
        ST_IDX0  = 9'b0_0000_0100,
        ST_IDX1  = 9'b0_0000_1000,
        ST_CHECK = 9'b0_0001_0000,
        ST_RDV   = 9'b0_0010_0000,
        ST_DEC   = 9'b0_0100_0000,
        ST_INC   = 9'b0_1000_0000,
        ST_PUSH  = 9'b1_0000_0000
    } t_state;

endpackage

FILE: hdl/vsc_if.sv
`timescale 1ns / 1ps

interface vsc_in_if import vsc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic        [ID_W-1:0]     new_type;

    modport source (output valid, pos_x, pos_y, pos_z, new_type, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, new_type, output ready);
endinterface

interface vsc_out_if import vsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    logic [ID_W-1:0]       prev_type;
    logic [CNT_OUT_W-1:0]  prev_type_count;
    logic [CNT_OUT_W-1:0]  new_type_count;

    modport source (output valid, accepted, prev_type, prev_type_count, new_type_count,
                    input ready);
    modport sink   (input valid, accepted, prev_type, prev_type_count, new_type_count,
                    output ready);
endinterface

interface vsc_cfg_if import vsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ID_W-1:0]  empty_type;

    modport source (output valid, empty_type, input ready);
    modport sink   (input valid, empty_type, output ready);
endinterface

FILE: hdl/vsc_alu.sv
`timescale 1ns / 1ps

module vsc_alu import vsc_pkg::*; #(
    parameter int W     = 21,
    parameter int DIM   = 32,
    parameter int CELLS = 32768
) (
    input  t_alu_op               i_op,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [W-1:0]   o_res
);

    localparam logic signed [W-1:0] K_DIM   = W'(DIM);
    localparam logic signed [W-1:0] K_CELLS = W'(CELLS);

    logic signed [W-1:0] prod;

    // Multiply by a constant only; the index is built by Horner's rule over two passes.
    assign prod = i_a * K_DIM;

    always_comb begin
        unique case (i_op)
            OP_MAC: begin
                o_res = prod + i_b;
            end
            OP_DEC: begin
                o_res = (i_a == '0) ? i_a : i_a - W'(1);
            end
            OP_INC: begin
                o_res = (i_a >= K_CELLS) ? i_a : i_a + W'(1);
            end
            default: begin
                o_res = i_a;
            end
        endcase
    end

endmodule

FILE: hdl/voxel_store_with_type_counts.sv
`timescale 1ns / 1ps
// Flow: an accepted input passes ST_IDX0 and ST_IDX1 (index by Horner's rule), ST_CHECK,
// then, if in range, ST_RDV, ST_DEC and ST_INC, and waits in ST_PUSH for a free output.
// A new input is taken only after the result is pushed and the state is back in ST_IDLE;
// the pace is set by the passes through the one shared arithmetic unit and the memory ports.
// Reset: synchronous; afterwards a clearing pass over every voxel and counter address
// empties the store and counters before any input is accepted.
module voxel_store_with_type_counts import vsc_pkg::*; #(
    parameter int DIM       = 32,
    parameter int TYPE_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vsc_in_if.sink       i_in,
    vsc_out_if.source    o_out,
    vsc_cfg_if.sink      i_cfg
);

    localparam int CELLS   = DIM * DIM * DIM;
    localparam int TYPES   = 2 ** TYPE_BITS;
    localparam int SUM_MAX = (2 ** (COORD_W - 1)) * (DIM * DIM + DIM + 1);
    localparam int IDX_W   = $clog2(SUM_MAX + 1) + 1;
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam int ALU_W   = (IDX_W > CNT_W + 1) ? IDX_W : CNT_W + 1;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int SWEEP   = (CELLS > TYPES) ? CELLS : TYPES;
    localparam int SW_W    = $clog2(SWEEP);

    localparam logic signed [ALU_W-1:0] K_CELLS = ALU_W'(CELLS);

    t_state r_state, n_state;

    logic [SW_W-1:0]                 r_clr, n_clr;
    logic [ID_W-1:0]                 r_empty;
    logic signed [COORD_W-1:0]       r_x, r_y, r_z;
    logic [ID_W-1:0]                 r_new;
    logic signed [ALU_W-1:0]         r_acc, n_acc;
    logic [TYPE_BITS-1:0]            r_pt, n_pt;
    logic [CNT_W-1:0]                r_pcnt, n_pcnt;

    logic                            r_res_acc, n_res_acc;
    logic [ID_W-1:0]                 r_res_pt, n_res_pt;
    logic [CNT_W-1:0]                r_res_pcnt, n_res_pcnt;
    logic [CNT_W-1:0]                r_res_ncnt, n_res_ncnt;

    logic                            r_o_valid, n_o_valid;
    logic                            r_o_acc;
    logic [ID_W-1:0]                 r_o_pt;
    logic [CNT_W-1:0]                r_o_pcnt, r_o_ncnt;

    // Voxel store and counter memories.
    logic [TYPE_BITS-1:0]            vox_mem [CELLS];
    logic [CNT_W-1:0]                cnt_mem [TYPES];
    logic [TYPE_BITS-1:0]            r_vox_rd;
    logic [CNT_W-1:0]                r_cnt_rd;

    logic                            vox_we;
    logic [ADDR_W-1:0]               vox_waddr, vox_raddr;
    logic [TYPE_BITS-1:0]            vox_wdata;
    logic                            cnt_we;
    logic [TYPE_BITS-1:0]            cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]                cnt_wdata, cnt_cur;

    t_alu_op                         alu_op;
    logic signed [ALU_W-1:0]         alu_a, alu_b, alu_res;

    logic [TYPE_BITS-1:0]            nt, et;
    logic                            in_acc, out_acc, push, in_range;
    logic                            clr_vox, clr_cnt;

    vsc_alu #(
        .W     (ALU_W),
        .DIM   (DIM),
        .CELLS (CELLS)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign nt       = TYPE_BITS'(r_new);
    assign et       = TYPE_BITS'(r_empty);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_acc  = r_o_valid && o_out.ready;
    assign push     = (r_state == ST_PUSH) && (!r_o_valid || o_out.ready);
    assign in_range = !r_acc[ALU_W-1] && (r_acc < K_CELLS);
    assign clr_vox  = ({1'b0, r_clr} < (SW_W + 1)'(CELLS));
    assign clr_cnt  = ({1'b0, r_clr} < (SW_W + 1)'(TYPES));
    assign vox_raddr = r_acc[ADDR_W-1:0];

    // When the new id equals the previous one, the read of its counter predates the decrement.
    assign cnt_cur = (nt == r_pt) ? r_pcnt : r_cnt_rd;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid           = r_o_valid;
    assign o_out.accepted        = r_o_acc;
    assign o_out.prev_type       = r_o_pt;
    assign o_out.prev_type_count = CNT_OUT_W'(r_o_pcnt);
    assign o_out.new_type_count  = CNT_OUT_W'(r_o_ncnt);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_acc      = r_acc;
        n_pt       = r_pt;
        n_pcnt     = r_pcnt;
        n_res_acc  = r_res_acc;
        n_res_pt   = r_res_pt;
        n_res_pcnt = r_res_pcnt;
        n_res_ncnt = r_res_ncnt;
        alu_op     = OP_MAC;
        alu_a      = '0;
        alu_b      = '0;
        vox_we     = 1'b0;
        vox_waddr  = r_acc[ADDR_W-1:0];
        vox_wdata  = nt;
        cnt_we     = 1'b0;
        cnt_waddr  = r_pt;
        cnt_wdata  = CNT_W'(alu_res);
        cnt_raddr  = r_pt;

        unique case (r_state)
            ST_CLEAR: begin
                vox_we    = clr_vox;
                vox_waddr = r_clr[ADDR_W-1:0];
                vox_wdata = '0;
                cnt_we    = clr_cnt;
                cnt_waddr = r_clr[TYPE_BITS-1:0];
                cnt_wdata = '0;
                n_clr     = r_clr + SW_W'(1);
                if (r_clr == SW_W'(SWEEP - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_IDX0;
                end
            end
            ST_IDX0: begin
                alu_a   = ALU_W'(r_x);
                alu_b   = ALU_W'(r_z);
                n_acc   = alu_res;
                n_state = ST_IDX1;
            end
            ST_IDX1: begin
                alu_a   = r_acc;
                alu_b   = ALU_W'(r_y);
                n_acc   = alu_res;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (in_range) begin
                    n_state = ST_RDV;
                end else begin
                    n_res_acc  = 1'b0;
                    n_res_pt   = r_empty;
                    n_res_pcnt = '0;
                    n_res_ncnt = '0;
                    n_state    = ST_PUSH;
                end
            end
            ST_RDV: begin
                vox_we    = 1'b1;
                n_pt      = r_vox_rd;
                cnt_raddr = r_vox_rd;
                n_state   = ST_DEC;
            end
            ST_DEC: begin
                alu_op    = OP_DEC;
                alu_a     = ALU_W'(r_cnt_rd);
                cnt_we    = (r_pt != et);
                cnt_waddr = r_pt;
                n_pcnt    = CNT_W'(alu_res);
                cnt_raddr = nt;
                n_state   = ST_INC;
            end
            ST_INC: begin
                alu_op     = OP_INC;
                alu_a      = ALU_W'(cnt_cur);
                cnt_we     = (nt != et);
                cnt_waddr  = nt;
                n_res_acc  = 1'b1;
                n_res_pt   = ID_W'(r_pt);
                n_res_ncnt = (nt != et) ? CNT_W'(alu_res) : '0;
                if (r_pt == et) begin
                    n_res_pcnt = '0;
                end else if (nt == r_pt) begin
                    n_res_pcnt = CNT_W'(alu_res);
                end else begin
                    n_res_pcnt = r_pcnt;
                end
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (push) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (push) begin
            n_o_valid = 1'b1;
        end else if (out_acc) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_empty   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_empty <= i_cfg.empty_type;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_pt       <= n_pt;
        r_pcnt     <= n_pcnt;
        r_res_acc  <= n_res_acc;
        r_res_pt   <= n_res_pt;
        r_res_pcnt <= n_res_pcnt;
        r_res_ncnt <= n_res_ncnt;
        if (in_acc) begin
            r_x   <= i_in.pos_x;
            r_y   <= i_in.pos_y;
            r_z   <= i_in.pos_z;
            r_new <= i_in.new_type;
        end
        if (push) begin
            r_o_acc  <= r_res_acc;
            r_o_pt   <= r_res_pt;
            r_o_pcnt <= r_res_pcnt;
            r_o_ncnt <= r_res_ncnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vox_we) begin
            vox_mem[vox_waddr] <= vox_wdata;
        end
        r_vox_rd <= vox_mem[vox_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= cnt_mem[cnt_raddr];
    end

    a_no_input_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !in_acc)
        else $error("input transaction taken during the clearing pass");

    a_count_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (cnt_wdata <= CNT_W'(CELLS)))
        else $error("type counter written beyond the number of cells");

    a_store_write_states : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vox_we |-> ((r_state == ST_CLEAR) || (r_state == ST_RDV)))
        else $error("voxel store written outside clearing or update");

    a_reject_zero_counts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_acc) |-> ((r_o_pcnt == '0) && (r_o_ncnt == '0)))
        else $error("rejected transaction carries non-zero counts");

endmodule
